FILE: src/mbcf_pkg.sv
// Shared types, constants and step tables for the multichannel biquad cascade filter.
package mbcf_pkg;

   localparam int CHANNELS  = 3;
   localparam int SAMPLE_W  = 24;
   localparam int CH_W      = 2;
   localparam int OUT_W     = 32;
   localparam int STATE_W   = 48;
   localparam int ACC_W     = 64;
   localparam int COEF_W    = 32;
   localparam int HALF_W    = 24;
   localparam int PROD_W    = HALF_W + 1 + COEF_W;
   localparam int STEP_W    = 5;
   localparam int COEF_IDX_W = 4;

   localparam logic [STEP_W-1:0] SEC1_LAST  = 5'd6;
   localparam logic [STEP_W-1:0] SEC2_FIRST = 5'd7;
   localparam logic [STEP_W-1:0] LAST_STEP  = 5'd16;

   typedef enum logic [3:0] {
      SEL_X0, SEL_X1, SEL_X2, SEL_Y1A, SEL_Y1B,
      SEL_MID, SEL_M1, SEL_M2, SEL_Z1, SEL_Z2
   } sel_type;

   typedef enum logic [1:0] {
      PART_FULL, PART_LO, PART_HI
   } part_type;

   typedef struct packed {
      sel_type                 sel;
      part_type                part;
      logic [COEF_IDX_W-1:0]   coef_idx;
   } step_type;

   typedef struct packed {
      logic     load_sample;
      logic     load_state;
      logic     mul_en;
      logic     first;
      step_type step;
      logic     round;
      logic     mid;
      logic     finish;
      logic     zero_out;
   } cmd_type;

   // feedback coefficients are stored negated so every term is added
   function automatic logic signed [COEF_W-1:0] coef_of(input logic [COEF_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      unique case (idx)
         4'd0:    c = 32'sd160028528;
         4'd1:    c = 32'sd320057057;
         4'd2:    c = 32'sd160028528;
         4'd3:    c = 32'sd892284803;
         4'd4:    c = -32'sd372894784;
         4'd5:    c = 32'sd536870912;
         4'd6:    c = 32'sd1073741824;
         4'd7:    c = 32'sd536870912;
         4'd8:    c = 32'sd979949285;
         4'd9:    c = -32'sd462276714;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic step_type step_of(input logic [STEP_W-1:0] idx);
      step_type s;
      unique case (idx)
         5'd0:    s = '{SEL_X0,  PART_FULL, 4'd0};
         5'd1:    s = '{SEL_X1,  PART_FULL, 4'd1};
         5'd2:    s = '{SEL_X2,  PART_FULL, 4'd2};
         5'd3:    s = '{SEL_Y1A, PART_LO,   4'd3};
         5'd4:    s = '{SEL_Y1A, PART_HI,   4'd3};
         5'd5:    s = '{SEL_Y1B, PART_LO,   4'd4};
         5'd6:    s = '{SEL_Y1B, PART_HI,   4'd4};
         5'd7:    s = '{SEL_MID, PART_LO,   4'd5};
         5'd8:    s = '{SEL_MID, PART_HI,   4'd5};
         5'd9:    s = '{SEL_M1,  PART_LO,   4'd6};
         5'd10:   s = '{SEL_M1,  PART_HI,   4'd6};
         5'd11:   s = '{SEL_M2,  PART_LO,   4'd7};
         5'd12:   s = '{SEL_M2,  PART_HI,   4'd7};
         5'd13:   s = '{SEL_Z1,  PART_LO,   4'd8};
         5'd14:   s = '{SEL_Z1,  PART_HI,   4'd8};
         5'd15:   s = '{SEL_Z2,  PART_LO,   4'd9};
         5'd16:   s = '{SEL_Z2,  PART_HI,   4'd9};
         default: s = '{SEL_X0,  PART_FULL, 4'd0};
      endcase
      return s;
   endfunction

endpackage

FILE: src/multichannel_biquad_cascade_filter.sv
// Top level of the three-channel two-section biquad cascade filter.
//
//   port group  direction  payload
//   req_        in         sample (s24, Q23), channel (u2)
//   rsp_        out        filtered (s32)
//
// Each word takes 17 passes through the single 25x32 multiplier plus rounding
// and write-back steps; req_stall holds off the next word until the done step.
// A word in an unused channel skips to the done step, returns zero and touches no state.
// The output register frees the core; a stalled result holds only the done step.
// Synchronous reset clears all delay registers and the handshakes.
module multichannel_biquad_cascade_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [mbcf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [mbcf_pkg::CH_W-1:0]            req_channel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mbcf_pkg::OUT_W-1:0]    rsp_filtered
);
   import mbcf_pkg::*;

   cmd_type cmd;

   mbcf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_channel (req_channel),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd)
   );

   mbcf_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_sample   (req_sample),
      .req_channel  (req_channel),
      .rsp_filtered (rsp_filtered)
   );

endmodule

FILE: src/mbcf_datapath.sv
// Datapath: per-channel delay registers, shared multiplier, accumulator and rounding.
module mbcf_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mbcf_pkg::cmd_type                    cmd,
   input  logic signed [mbcf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [mbcf_pkg::CH_W-1:0]            req_channel,
   output logic signed [mbcf_pkg::OUT_W-1:0]    rsp_filtered
);
   import mbcf_pkg::*;

   typedef struct packed {
      logic [SAMPLE_W-1:0] x1;
      logic [SAMPLE_W-1:0] x2;
      logic [STATE_W-1:0]  y1a;
      logic [STATE_W-1:0]  y1b;
      logic [STATE_W-1:0]  m1;
      logic [STATE_W-1:0]  m2;
      logic [STATE_W-1:0]  z1;
      logic [STATE_W-1:0]  z2;
   } chan_type;

   chan_type                   chan_ff [CHANNELS];
   chan_type                   st_ff;
   logic [SAMPLE_W-1:0]        x0_ff;
   logic [CH_W-1:0]            ch_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       prod_vld_ff, prod_first_ff, prod_hi_ff;
   logic [ACC_W-1:0]           acc_ff, acc_in, addend, prod_ext, rnd;
   logic [STATE_W-1:0]         y1_ff, mid_ff, mid_sum, y_round, operand;
   logic signed [HALF_W:0]     mul_a;
   logic signed [OUT_W-1:0]    filtered_ff;
   chan_type                   st_next;

   always_comb begin
      case (cmd.step.sel)
         SEL_X0:  operand = {{(STATE_W-SAMPLE_W){x0_ff[SAMPLE_W-1]}}, x0_ff};
         SEL_X1:  operand = {{(STATE_W-SAMPLE_W){st_ff.x1[SAMPLE_W-1]}}, st_ff.x1};
         SEL_X2:  operand = {{(STATE_W-SAMPLE_W){st_ff.x2[SAMPLE_W-1]}}, st_ff.x2};
         SEL_Y1A: operand = st_ff.y1a;
         SEL_Y1B: operand = st_ff.y1b;
         SEL_MID: operand = mid_ff;
         SEL_M1:  operand = st_ff.m1;
         SEL_M2:  operand = st_ff.m2;
         SEL_Z1:  operand = st_ff.z1;
         SEL_Z2:  operand = st_ff.z2;
         default: operand = '0;
      endcase
      case (cmd.step.part)
         PART_FULL: mul_a = {operand[HALF_W-1], operand[HALF_W-1:0]};
         PART_LO:   mul_a = {1'b0, operand[HALF_W-1:0]};
         PART_HI:   mul_a = {operand[STATE_W-1], operand[STATE_W-1:HALF_W]};
         default:   mul_a = '0;
      endcase
   end

   assign prod_in  = mul_a * coef_of(cmd.step.coef_idx);
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign addend   = prod_hi_ff ? {prod_ext[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}} : prod_ext;
   assign acc_in   = (prod_first_ff ? '0 : acc_ff) + addend;

   // rounded section output: (acc + 2^28) >>> 29, held in 48 bits
   assign rnd     = acc_ff + (ACC_W'(1) << 28);
   assign y_round = {{(STATE_W-(ACC_W-29)){rnd[ACC_W-1]}}, rnd[ACC_W-1:29]};
   assign mid_sum = y1_ff + STATE_W'(16);

   always_comb begin
      st_next     = st_ff;
      st_next.x1  = x0_ff;
      st_next.x2  = st_ff.x1;
      st_next.y1a = y1_ff;
      st_next.y1b = st_ff.y1a;
      st_next.m1  = mid_ff;
      st_next.m2  = st_ff.m1;
      st_next.z1  = y_round;
      st_next.z2  = st_ff.z1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            chan_ff[i] <= '0;
         end
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_en;
         if (cmd.finish && !cmd.zero_out) begin
            chan_ff[ch_ff] <= st_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         x0_ff <= req_sample;
         ch_ff <= req_channel;
      end
      if (cmd.load_state) begin
         st_ff <= chan_ff[req_channel];
      end
      prod_ff       <= prod_in;
      prod_first_ff <= cmd.first;
      prod_hi_ff    <= (cmd.step.part == PART_HI);
      if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.round) begin
         y1_ff <= y_round;
      end
      if (cmd.mid) begin
         mid_ff <= {{5{mid_sum[STATE_W-1]}}, mid_sum[STATE_W-1:5]};
      end
      if (cmd.finish) begin
         filtered_ff <= cmd.zero_out ? '0 : y_round[OUT_W+5:6];
      end
   end

   assign rsp_filtered = filtered_ff;

endmodule

FILE: src/mbcf_ctrl.sv
// Controller: sequences the multiply-accumulate steps and owns the handshakes.
module mbcf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [mbcf_pkg::CH_W-1:0] req_channel,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mbcf_pkg::cmd_type         cmd
);
   import mbcf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC, ST_WAIT1, ST_ROUND, ST_MID, ST_WAIT2, ST_DONE
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              zero_ff;
   logic              rsp_valid_ff;
   logic              accept, chan_ok, slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign chan_ok   = int'(req_channel) < CHANNELS;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd             = '0;
      cmd.load_sample = accept;
      cmd.load_state  = accept && chan_ok;
      cmd.mul_en      = (state_ff == ST_MAC);
      cmd.first       = (state_ff == ST_MAC) && (step_ff == '0 || step_ff == SEC2_FIRST);
      cmd.step        = step_of(step_ff);
      cmd.round       = (state_ff == ST_ROUND);
      cmd.mid         = (state_ff == ST_MID);
      cmd.finish      = (state_ff == ST_DONE) && slot_free;
      cmd.zero_out    = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  step_ff  <= '0;
                  zero_ff  <= !chan_ok;
                  state_ff <= chan_ok ? ST_MAC : ST_DONE;
               end
            end
            ST_MAC: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == SEC1_LAST) begin
                  state_ff <= ST_WAIT1;
               end else if (step_ff == LAST_STEP) begin
                  state_ff <= ST_WAIT2;
               end
            end
            ST_WAIT1: state_ff <= ST_ROUND;
            ST_ROUND: state_ff <= ST_MID;
            ST_MID:   state_ff <= ST_MAC;
            ST_WAIT2: state_ff <= ST_DONE;
            ST_DONE: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start processing");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (step_ff <= LAST_STEP))
      else $error("step counter past last step");

   a_wait1_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT1) |-> (step_ff == SEC2_FIRST))
      else $error("first section ended at wrong step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside done state");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the multichannel biquad cascade filter.
module tb_top;

   typedef logic signed [mbcf_pkg::SAMPLE_W-1:0] sample_type;
   typedef logic [mbcf_pkg::CH_W-1:0]            channel_type;
   typedef logic signed [mbcf_pkg::OUT_W-1:0]    filtered_type;

   localparam longint S1_B0 = 160028528;
   localparam longint S1_B1 = 320057057;
   localparam longint S1_B2 = 160028528;
   localparam longint S1_A1 = -892284803;
   localparam longint S1_A2 = 372894784;
   localparam longint S2_B0 = 536870912;
   localparam longint S2_B1 = 1073741824;
   localparam longint S2_B2 = 536870912;
   localparam longint S2_A1 = -979949285;
   localparam longint S2_A2 = 462276714;

   localparam int     COEF_SHIFT = 29;
   localparam int     MID_SHIFT  = 5;
   localparam int     OUT_SHIFT  = 6;
   localparam longint COEF_ROUND = longint'(1) << (COEF_SHIFT - 1);
   localparam longint MID_ROUND  = longint'(1) << (MID_SHIFT - 1);

   localparam sample_type  SAMPLE_MAX = {1'b0, {(mbcf_pkg::SAMPLE_W-1){1'b1}}};
   localparam sample_type  SAMPLE_MIN = {1'b1, {(mbcf_pkg::SAMPLE_W-1){1'b0}}};
   localparam channel_type UNUSED_CH  = channel_type'(mbcf_pkg::CHANNELS);

   localparam int RESET_CYCLES   = 5;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int MAX_REPORTS    = 20;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   sample_type   req_sample  = '0;
   channel_type  req_channel = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   filtered_type rsp_filtered;

   multichannel_biquad_cascade_filter u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .req_channel  (req_channel),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // per-channel delay lines, [0] newest
   logic signed [mbcf_pkg::SAMPLE_W-1:0] s1_x_hist [mbcf_pkg::CHANNELS][2];
   logic signed [mbcf_pkg::STATE_W-1:0]  s1_y_hist [mbcf_pkg::CHANNELS][2];
   logic signed [mbcf_pkg::STATE_W-1:0]  s2_x_hist [mbcf_pkg::CHANNELS][2];
   logic signed [mbcf_pkg::STATE_W-1:0]  s2_y_hist [mbcf_pkg::CHANNELS][2];

   filtered_type pending_filtered [$];

   int  words_sent      = 0;
   int  unused_sent     = 0;
   int  results_checked = 0;
   int  failures        = 0;
   bit  tx_idle         = 1'b1;
   bit  rx_idle         = 1'b1;
   int  hold_left       = 0;

   function automatic longint section_out(input longint b0, b1, b2, a1, a2,
                                          input longint x0, x1, x2, y1, y2);
      longint acc;
      acc = b0 * x0 + b1 * x1 + b2 * x2 - a1 * y1 - a2 * y2 + COEF_ROUND;
      return acc >>> COEF_SHIFT;
   endfunction

   function automatic filtered_type cascade_predict(input sample_type sample,
                                                    input channel_type channel);
      longint y1;
      longint mid;
      longint y2;
      longint shifted;
      int     ch;
      ch = int'(channel);
      if (ch >= mbcf_pkg::CHANNELS) return '0;
      y1 = section_out(S1_B0, S1_B1, S1_B2, S1_A1, S1_A2, longint'(sample),
                       longint'(s1_x_hist[ch][0]), longint'(s1_x_hist[ch][1]),
                       longint'(s1_y_hist[ch][0]), longint'(s1_y_hist[ch][1]));
      s1_x_hist[ch][1] = s1_x_hist[ch][0];
      s1_x_hist[ch][0] = sample;
      s1_y_hist[ch][1] = s1_y_hist[ch][0];
      s1_y_hist[ch][0] = y1[mbcf_pkg::STATE_W-1:0];
      mid = (y1 + MID_ROUND) >>> MID_SHIFT;
      y2 = section_out(S2_B0, S2_B1, S2_B2, S2_A1, S2_A2, mid,
                       longint'(s2_x_hist[ch][0]), longint'(s2_x_hist[ch][1]),
                       longint'(s2_y_hist[ch][0]), longint'(s2_y_hist[ch][1]));
      s2_x_hist[ch][1] = s2_x_hist[ch][0];
      s2_x_hist[ch][0] = mid[mbcf_pkg::STATE_W-1:0];
      s2_y_hist[ch][1] = s2_y_hist[ch][0];
      s2_y_hist[ch][0] = y2[mbcf_pkg::STATE_W-1:0];
      shifted = y2 >>> OUT_SHIFT;
      return shifted[mbcf_pkg::OUT_W-1:0];
   endfunction

   // mostly none or short, now and then long
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sample_type pick_sample();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return SAMPLE_MAX;
      if (r == 1) return SAMPLE_MIN;
      if (r == 2) return sample_type'($signed($urandom_range(0, 511)) - 256);
      return sample_type'($urandom);
   endfunction

   function automatic channel_type pick_channel();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 9) return UNUSED_CH;
      return channel_type'(r % mbcf_pkg::CHANNELS);
   endfunction

   task automatic send_word(input sample_type sample, input channel_type channel);
      int gap;
      req_valid   <= 1'b1;
      req_sample  <= sample;
      req_channel <= channel;
      do @(posedge clock); while (!(req_valid && !req_stall));
      pending_filtered.push_back(cascade_predict(sample, channel));
      words_sent++;
      if (int'(channel) >= mbcf_pkg::CHANNELS) unused_sent++;
      gap = tx_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_extremes();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      repeat (5) send_word(SAMPLE_MAX, channel_type'(0));
      repeat (5) send_word(SAMPLE_MIN, channel_type'(1));
      repeat (2) begin
         send_word(SAMPLE_MAX, channel_type'(2));
         send_word(SAMPLE_MIN, channel_type'(2));
      end
      send_word(SAMPLE_MAX, UNUSED_CH);
      send_word(SAMPLE_MIN, UNUSED_CH);
      send_word(sample_type'(-1), UNUSED_CH);
      send_word(sample_type'(0), channel_type'(0));
      send_word(sample_type'(-1), channel_type'(0));
      send_word(sample_type'(1), channel_type'(1));
      send_word(sample_type'(0), channel_type'(2));
   endtask

   task automatic test_random_mix();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      repeat (520) send_word(pick_sample(), pick_channel());
   endtask

   // held levels with dithered low bits let the delay lines settle
   task automatic test_step_runs();
      int          sent;
      int          len;
      channel_type ch;
      sample_type  level;
      sent = 0;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      while (sent < 400) begin
         ch    = channel_type'($urandom_range(0, mbcf_pkg::CHANNELS - 1));
         level = pick_sample();
         len   = $urandom_range(3, 30);
         repeat (len) begin
            if ($urandom_range(0, 7) == 0) send_word(pick_sample(), pick_channel());
            else send_word(level ^ sample_type'($urandom_range(0, 7)), ch);
            sent++;
         end
      end
   endtask

   task automatic test_backpressure();
      tx_idle   = 1'b0;
      rx_idle   = 1'b1;
      hold_left = HOLD_CYCLES;
      repeat (16) send_word(pick_sample(), pick_channel());
      while (hold_left > 0) @(posedge clock);
   endtask

   task automatic test_burst();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      repeat (100) send_word(pick_sample(), pick_channel());
   endtask

   // result side stall pattern
   initial begin
      int stall_left;
      int open_left;
      stall_left = 0;
      open_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!rx_idle) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (open_left > 0) begin
            open_left--;
            rsp_stall <= 1'b0;
         end else begin
            stall_left = pick_gap();
            open_left  = $urandom_range(1, 12);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      filtered_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (pending_filtered.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected word, got filtered %0d", $time, rsp_filtered);
         end else begin
            want = pending_filtered.pop_front();
            if (rsp_filtered !== want) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: filtered mismatch, expected %0d, got %0d",
                           $time, want, rsp_filtered);
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_filtered.size());
      $display("** multichannel_biquad_cascade_filter: FAILED **");
      $finish;
   end

   initial begin
      for (int c = 0; c < mbcf_pkg::CHANNELS; c++) begin
         for (int k = 0; k < 2; k++) begin
            s1_x_hist[c][k] = '0;
            s1_y_hist[c][k] = '0;
            s2_x_hist[c][k] = '0;
            s2_y_hist[c][k] = '0;
         end
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_random_mix();
      test_step_runs();
      test_backpressure();
      test_burst();

      req_valid <= 1'b0;
      rx_idle = 1'b0;
      while (pending_filtered.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words (%0d on the unused channel), checked %0d results, %0d errors",
               words_sent, unused_sent, results_checked, failures);
      $display("Covered sample extremes, random mix, held steps, %0d-cycle hold-off, burst",
               HOLD_CYCLES);
      if (failures == 0) begin
         $display("** multichannel_biquad_cascade_filter: PASSED **");
      end else begin
         $display("** multichannel_biquad_cascade_filter: FAILED **");
      end
      $finish;
   end

endmodule
